>>> hdl/ccd_pkg.sv
package ccd_pkg;

	// Field and register widths
	localparam int unsigned SAMPLE_W   = 64;
	localparam int unsigned EPOCH_W    = 40;
	localparam int unsigned BOOT_EP_W  = 38;
	localparam int unsigned FREQ_W     = 34;
	localparam int unsigned YEAR_W     = 14;
	localparam int unsigned MONTH_W    = 4;
	localparam int unsigned DAY_W      = 5;
	localparam int unsigned HOUR_W     = 5;
	localparam int unsigned MINUTE_W   = 6;
	localparam int unsigned SECOND_W   = 6;
	localparam int unsigned DAYS_W     = 22;
	localparam int unsigned OUT_DATA_W = 80;
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 64;

	// Serial divider sizing
	localparam int unsigned DIV_DVD_W = 64;
	localparam int unsigned DIV_DVS_W = 34;
	localparam int unsigned DIV_CNT_W = 7;

	// Walker sizing
	localparam int unsigned BLK_W  = 18;
	localparam int unsigned INC_W  = 9;
	localparam int unsigned M400_W = 9;

	// Register map, decoded on paddr[4:3]
	localparam logic [1:0] REG_BOOT_EPOCH   = 2'd0;
	localparam logic [1:0] REG_BOOT_COUNTER = 2'd1;
	localparam logic [1:0] REG_COUNTER_FREQ = 2'd2;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 34'd1000000000;

	// Calendar constants
	localparam logic [EPOCH_W-1:0] EPOCH_MAX       = 40'hFF_FFFF_FFFF;
	localparam logic [EPOCH_W-1:0] YEAR10000_START = 40'd253402300800;
	localparam logic [DIV_DVS_W-1:0] SECS_PER_DAY  = 34'd86400;
	localparam logic [DIV_DVS_W-1:0] SECS_PER_HOUR = 34'd3600;
	localparam logic [DIV_DVS_W-1:0] SECS_PER_MIN  = 34'd60;
	localparam logic [YEAR_W-1:0] EPOCH_YEAR       = 14'd1970;
	localparam logic [YEAR_W-1:0] CYCLE_YEAR       = 14'd2000;
	localparam logic [M400_W-1:0] EPOCH_YEAR_M400  = 9'd370;
	localparam logic [YEAR_W-1:0] CLAMP_YEAR       = 14'd9999;
	localparam logic [MONTH_W-1:0] CLAMP_MONTH     = 4'd12;
	localparam logic [DAY_W-1:0] CLAMP_DAY         = 5'd31;
	localparam logic [HOUR_W-1:0] CLAMP_HOUR       = 5'd23;
	localparam logic [MINUTE_W-1:0] CLAMP_MINUTE   = 6'd59;
	localparam logic [SECOND_W-1:0] CLAMP_SECOND   = 6'd59;
	localparam logic [MONTH_W-1:0] MONTH_IDX_DEC   = 4'd11;

	localparam logic [BLK_W-1:0] DAYS_400Y      = 18'd146097;
	localparam logic [BLK_W-1:0] DAYS_100Y_LEAP = 18'd36525;
	localparam logic [BLK_W-1:0] DAYS_100Y      = 18'd36524;
	localparam logic [BLK_W-1:0] DAYS_4Y        = 18'd1461;
	localparam logic [BLK_W-1:0] DAYS_4Y_NOLEAP = 18'd1460;
	localparam logic [BLK_W-1:0] DAYS_LEAP_YEAR = 18'd366;
	localparam logic [BLK_W-1:0] DAYS_YEAR      = 18'd365;

	// Top-level sequencer
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DIV_SEC,
		CS_EPOCH,
		CS_DIV_DAY,
		CS_DIV_HOUR,
		CS_DIV_MIN,
		CS_WAIT_WALK,
		CS_DONE
	} core_state_t;

	// Year and month walker phases
	typedef enum logic [2:0] {
		WP_IDLE,
		WP_PRE,
		WP_400,
		WP_100,
		WP_4,
		WP_1,
		WP_MON
	} walk_phase_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] nbits;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic [DIV_DVD_W-1:0] quotient;
		logic [DIV_DVS_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DAYS_W-1:0] days;
	} walk_req_t;

	typedef struct packed {
		logic               busy;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} walk_rsp_t;

	// Days in month, month index 0 is January
	function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] d;
		case (m) inside
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
			4'd1: d = leap ? 5'd29 : 5'd28;
			default: d = 5'd30;
		endcase
		return d;
	endfunction

endpackage

>>> hdl/counter_to_calendar_datetime_core.sv
// Channel      Dir  Handshake        Content
// s (sample)   in   s_tvalid/ready   s_tdata: counter_sample
// m (datetime) out  m_tvalid/ready   m_tdata: epoch, date, time; m_tuser: out_of_range
// apb (config) in   psel/penable     boot_epoch_seconds, boot_counter_value, freq
//
// One sample at a time. The bit-serial divider (64 steps for ticks/frequency, then 38,
// 17 and 12 steps for days, hours and minutes) and the year/month walker, which runs
// beside the last two divisions, set how long a sample takes; a clamped date skips the
// day, hour and minute divisions and the walker.
// The finished result sits in an output register, so the next sample is taken while
// it waits; only the final hand-off stalls when that register is still full.
// Reset clears the sequencer, the walker, the output valid flag and the configuration registers (frequency to 1 GHz).
module counter_to_calendar_datetime_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ccd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ccd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ccd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// Sample stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ccd_pkg::SAMPLE_W-1:0]     s_tdata,   // [63:0] counter_sample
	// Date/time stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [39:0] epoch_seconds, [53:40] year, [57:54] month, [62:58] day_of_month,
	// [67:63] hour, [73:68] minute, [79:74] second
	output logic [ccd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [0:0]                       m_tuser    // [0] out_of_range
);
	import ccd_pkg::*;

	core_state_t           state_q;
	core_state_t           state_d;

	logic [BOOT_EP_W-1:0]  boot_epoch_q;
	logic [SAMPLE_W-1:0]   boot_counter_q;
	logic [FREQ_W-1:0]     freq_q;

	logic [EPOCH_W-1:0]    ts_q;
	logic                  oor_q;
	logic [HOUR_W-1:0]     hour_q;
	logic [MINUTE_W-1:0]   minute_q;
	logic [SECOND_W-1:0]   second_q;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_user_q;

	div_req_t              div_req;
	div_rsp_t              div_rsp;
	walk_req_t             walk_req;
	walk_rsp_t             walk_rsp;

	logic                  cfg_write;
	logic                  s_accept;
	logic                  load_out;
	logic                  div_done;
	logic [EPOCH_W:0]      sum_w;
	logic                  sat_w;
	logic [EPOCH_W-1:0]    ts_w;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign s_tready  = (state_q == CS_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign div_done  = !div_rsp.busy;
	assign load_out  = (state_q == CS_DONE) && (!m_valid_q || m_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_epoch_q   <= '0;
			boot_counter_q <= '0;
			freq_q         <= FREQ_RESET;
		end else if (cfg_write) begin
			unique case (paddr[4:3])
				REG_BOOT_EPOCH:   boot_epoch_q   <= pwdata[BOOT_EP_W-1:0];
				REG_BOOT_COUNTER: boot_counter_q <= pwdata[SAMPLE_W-1:0];
				REG_COUNTER_FREQ: freq_q         <= pwdata[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[4:3])
			REG_BOOT_EPOCH:   prdata = {{(APB_DATA_W-BOOT_EP_W){1'b0}}, boot_epoch_q};
			REG_BOOT_COUNTER: prdata = boot_counter_q;
			REG_COUNTER_FREQ: prdata = {{(APB_DATA_W-FREQ_W){1'b0}}, freq_q};
			default:          prdata = '0;
		endcase
	end

	// Epoch seconds with saturation; the year 10000 check is made when the result is captured
	always_comb begin
		sum_w = {1'b0, div_rsp.quotient[EPOCH_W-1:0]} +
			{{(EPOCH_W+1-BOOT_EP_W){1'b0}}, boot_epoch_q};
		sat_w = (|div_rsp.quotient[DIV_DVD_W-1:EPOCH_W]) || sum_w[EPOCH_W];
		ts_w  = sat_w ? EPOCH_MAX : sum_w[EPOCH_W-1:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:      if (s_accept) state_d = CS_DIV_SEC;
			CS_DIV_SEC:   if (div_done) state_d = CS_EPOCH;
			CS_EPOCH:     state_d = oor_q ? CS_DONE : CS_DIV_DAY;
			CS_DIV_DAY:   if (div_done) state_d = CS_DIV_HOUR;
			CS_DIV_HOUR:  if (div_done) state_d = CS_DIV_MIN;
			CS_DIV_MIN:   if (div_done) state_d = CS_WAIT_WALK;
			CS_WAIT_WALK: if (!walk_rsp.busy) state_d = CS_DONE;
			CS_DONE:      if (load_out) state_d = CS_IDLE;
			default:      state_d = CS_IDLE;
		endcase
	end

	// Divider and walker requests per state
	always_comb begin
		div_req  = '0;
		walk_req = '0;
		unique case (state_q)
			CS_IDLE: begin
				div_req.start    = s_accept;
				div_req.nbits    = DIV_CNT_W'(SAMPLE_W);
				div_req.dividend = s_tdata - boot_counter_q;
				div_req.divisor  = (freq_q == '0) ? DIV_DVS_W'(1) : freq_q;
			end
			CS_EPOCH: begin
				div_req.start    = !oor_q;
				div_req.nbits    = DIV_CNT_W'(BOOT_EP_W);
				div_req.dividend = {ts_q[BOOT_EP_W-1:0], {(DIV_DVD_W-BOOT_EP_W){1'b0}}};
				div_req.divisor  = SECS_PER_DAY;
			end
			CS_DIV_DAY: begin
				div_req.start    = div_done;
				div_req.nbits    = DIV_CNT_W'(17);
				div_req.dividend = {div_rsp.remainder[16:0], {(DIV_DVD_W-17){1'b0}}};
				div_req.divisor  = SECS_PER_HOUR;
				walk_req.start   = div_done;
				walk_req.days    = div_rsp.quotient[DAYS_W-1:0];
			end
			CS_DIV_HOUR: begin
				div_req.start    = div_done;
				div_req.nbits    = DIV_CNT_W'(12);
				div_req.dividend = {div_rsp.remainder[11:0], {(DIV_DVD_W-12){1'b0}}};
				div_req.divisor  = SECS_PER_MIN;
			end
			default: begin
				div_req  = '0;
				walk_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the epoch, hour, minute and second results as their divisions finish
	always_ff @(posedge clk) begin
		if (state_q == CS_DIV_SEC && div_done) begin
			ts_q  <= ts_w;
			oor_q <= ts_w >= YEAR10000_START;
		end
		if (state_q == CS_DIV_HOUR && div_done) begin
			hour_q <= div_rsp.quotient[HOUR_W-1:0];
		end
		if (state_q == CS_DIV_MIN && div_done) begin
			minute_q <= div_rsp.quotient[MINUTE_W-1:0];
			second_q <= div_rsp.remainder[SECOND_W-1:0];
		end
	end

	// Output register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_user_q <= oor_q;
			if (oor_q) begin
				m_data_q <= {CLAMP_SECOND, CLAMP_MINUTE, CLAMP_HOUR, CLAMP_DAY, CLAMP_MONTH,
					CLAMP_YEAR, ts_q};
			end else begin
				m_data_q <= {second_q, minute_q, hour_q, walk_rsp.day, walk_rsp.month,
					walk_rsp.year, ts_q};
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	ccd_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ccd_date_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (walk_req),
		.rsp    (walk_rsp)
	);

endmodule

>>> hdl/ccd_serial_div.sv
module ccd_serial_div (
	input  logic             clk,
	input  logic             arst_n,
	input  ccd_pkg::div_req_t req,
	output ccd_pkg::div_rsp_t rsp
);
	import ccd_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_DVS_W-1:0] rem_q;

	logic [DIV_DVS_W:0]   partial;
	logic [DIV_DVS_W:0]   diff;
	logic                 ge;
	logic [DIV_DVS_W-1:0] rem_next;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		partial  = {rem_q, dvd_q[DIV_DVD_W-1]};
		diff     = partial - {1'b0, dvs_q};
		ge       = partial >= {1'b0, dvs_q};
		rem_next = ge ? diff[DIV_DVS_W-1:0] : partial[DIV_DVS_W-1:0];
	end

	// Step count and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Dividend shifts out at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

>>> hdl/ccd_date_walk.sv
module ccd_date_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  ccd_pkg::walk_req_t req,
	output ccd_pkg::walk_rsp_t rsp
);
	import ccd_pkg::*;

	walk_phase_t         phase_q;
	walk_phase_t         phase_d;
	logic [DAYS_W-1:0]   days_q;
	logic [YEAR_W-1:0]   year_q;
	logic [M400_W-1:0]   m400_q;
	logic [MONTH_W-1:0]  mon_q;

	logic                leap;
	logic                century_start;
	logic [BLK_W-1:0]    blk;
	logic [INC_W-1:0]    inc;
	logic                take;
	logic                at_cycle;
	logic                step_year;
	logic                step_mon;
	logic [M400_W:0]     m400_sum;
	logic [M400_W-1:0]   m400_next;

	// Leap year from the year's place in the 400-year cycle
	always_comb begin
		century_start = (m400_q == 9'd100) || (m400_q == 9'd200) || (m400_q == 9'd300);
		leap          = (m400_q[1:0] == 2'd0) && !century_start;
		at_cycle      = (year_q == CYCLE_YEAR);
	end

	// Block length in days and year increment for the current phase
	always_comb begin
		blk = '0;
		inc = '0;
		unique case (phase_q)
			WP_PRE, WP_1: begin
				blk = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
				inc = 9'd1;
			end
			WP_400: begin
				blk = DAYS_400Y;
				inc = 9'd400;
			end
			WP_100: begin
				blk = (m400_q == '0) ? DAYS_100Y_LEAP : DAYS_100Y;
				inc = 9'd100;
			end
			WP_4: begin
				blk = century_start ? DAYS_4Y_NOLEAP : DAYS_4Y;
				inc = 9'd4;
			end
			WP_MON: begin
				blk = {{(BLK_W-DAY_W){1'b0}}, days_in_month(mon_q, leap)};
			end
			default: begin
				blk = '0;
				inc = '0;
			end
		endcase
		take = days_q >= {{(DAYS_W-BLK_W){1'b0}}, blk};
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			WP_IDLE: if (req.start) phase_d = WP_PRE;
			WP_PRE: begin
				if (at_cycle) phase_d = WP_400;
				else if (!take) phase_d = WP_MON;
			end
			WP_400: if (!take) phase_d = WP_100;
			WP_100: if (!take) phase_d = WP_4;
			WP_4:   if (!take) phase_d = WP_1;
			WP_1:   if (!take) phase_d = WP_MON;
			WP_MON: if (!take || mon_q == MONTH_IDX_DEC) phase_d = WP_IDLE;
			default: phase_d = WP_IDLE;
		endcase
	end

	// Step enables and cycle position update
	always_comb begin
		step_year = take && ((phase_q == WP_PRE && !at_cycle) || phase_q == WP_400 ||
			phase_q == WP_100 || phase_q == WP_4 || phase_q == WP_1);
		step_mon  = take && (phase_q == WP_MON) && (mon_q != MONTH_IDX_DEC);
		m400_sum  = {1'b0, m400_q} + {1'b0, inc};
		m400_next = (m400_sum >= 10'd400) ? M400_W'(m400_sum - 10'd400) : m400_sum[M400_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= WP_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Consume whole blocks of days, then whole months
	always_ff @(posedge clk) begin
		if (req.start && phase_q == WP_IDLE) begin
			days_q <= req.days;
			year_q <= EPOCH_YEAR;
			m400_q <= EPOCH_YEAR_M400;
			mon_q  <= '0;
		end else if (step_year) begin
			days_q <= days_q - {{(DAYS_W-BLK_W){1'b0}}, blk};
			year_q <= year_q + {{(YEAR_W-INC_W){1'b0}}, inc};
			m400_q <= m400_next;
		end else if (step_mon) begin
			days_q <= days_q - {{(DAYS_W-BLK_W){1'b0}}, blk};
			mon_q  <= mon_q + 1'b1;
		end
	end

	assign rsp.busy  = (phase_q != WP_IDLE);
	assign rsp.year  = year_q;
	assign rsp.month = mon_q + 1'b1;
	assign rsp.day   = days_q[DAY_W-1:0] + 1'b1;

endmodule

>>> hdl/ccd_checker.sv
module ccd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ccd_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]                     m_tuser
);
	import ccd_pkg::*;

	// Result holds while the sink stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// One sample in flight: no second transaction right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample accepted while busy");

	// Clamped results carry the last representable date
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[53:40] == CLAMP_YEAR &&
			m_tdata[57:54] == CLAMP_MONTH && m_tdata[62:58] == CLAMP_DAY &&
			m_tdata[39:0] >= YEAR10000_START)
		else $error("out-of-range result not clamped");

	// In-range results are a legal date and time
	a_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[39:0] < YEAR10000_START &&
			m_tdata[57:54] >= 4'd1 && m_tdata[57:54] <= 4'd12 &&
			m_tdata[62:58] >= 5'd1 && m_tdata[67:63] <= 5'd23 &&
			m_tdata[73:68] <= 6'd59 && m_tdata[79:74] <= 6'd59)
		else $error("illegal date or time");

endmodule

bind counter_to_calendar_datetime_core ccd_checker u_ccd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import ccd_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned SETTLE_CYCLES = 250;
	localparam logic [1:0]  REG_UNUSED    = 2'd3;
	localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] FREQ_MAX      = 64'd10000000000;

	typedef struct packed {
		logic [EPOCH_W-1:0]  epoch;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic                oor;
	} datetime_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata = '0;   // [63:0] counter_sample
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [39:0] epoch_seconds, [53:40] year, [57:54] month, [62:58] day_of_month,
	// [67:63] hour, [73:68] minute, [79:74] second
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;   // [0] out_of_range

	// Register copies used for prediction
	logic [BOOT_EP_W-1:0] cfg_boot_ep = '0;
	logic [63:0]          cfg_boot_cnt = '0;
	logic [FREQ_W-1:0]    cfg_freq = FREQ_RESET;

	logic [63:0] sample_q[$];
	datetime_t   datetime_q[$];

	int unsigned items_queued = 0;
	int unsigned results_seen = 0;
	int unsigned clamped_seen = 0;
	int unsigned settings_n = 0;
	int unsigned mismatches = 0;
	int unsigned quiet = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	bit          idle_en = 1'b1;

	counter_to_calendar_datetime_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("ERROR %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] eff_freq();
		return (cfg_freq == '0) ? 64'd1 : 64'(cfg_freq);
	endfunction

	// Day number of January 1st of year y, counted from 1970-01-01
	function automatic logic [63:0] days_to_year(input int unsigned y);
		int unsigned n;
		n = y - 1;
		// 477 leap days lie before 1970
		return 64'(365 * (y - 1970)) + 64'(n / 4) - 64'(n / 100) + 64'(n / 400) - 64'd477;
	endfunction

	// Expected date and time for one counter sample under the current registers
	function automatic datetime_t calc_datetime(input logic [63:0] sample);
		datetime_t   r;
		logic [63:0] secs, ts, days, sod, dim;
		int unsigned yr, mi;
		bit          done;
		secs = (sample - cfg_boot_cnt) / eff_freq();
		if (secs > 64'(EPOCH_MAX) - 64'(cfg_boot_ep))
			ts = 64'(EPOCH_MAX);
		else
			ts = 64'(cfg_boot_ep) + secs;
		r.epoch = ts[EPOCH_W-1:0];
		if (ts >= 64'(YEAR10000_START)) begin
			r.oor = 1'b1;
			r.year = CLAMP_YEAR;
			r.month = CLAMP_MONTH;
			r.day = CLAMP_DAY;
			r.hour = CLAMP_HOUR;
			r.minute = CLAMP_MINUTE;
			r.second = CLAMP_SECOND;
		end else begin
			r.oor = 1'b0;
			days = ts / 86400;
			sod = ts % 86400;
			r.hour = HOUR_W'(sod / 3600);
			r.minute = MINUTE_W'((sod % 3600) / 60);
			r.second = SECOND_W'(sod % 60);
			// walk whole years from 1970
			yr = 1970;
			dim = is_leap(yr) ? 64'd366 : 64'd365;
			while (days >= dim) begin
				days -= dim;
				yr++;
				dim = is_leap(yr) ? 64'd366 : 64'd365;
			end
			// walk months, December takes whatever is left
			mi = 0;
			done = 1'b0;
			while (!done) begin
				case (mi)
					1: dim = is_leap(yr) ? 64'd29 : 64'd28;
					3, 5, 8, 10: dim = 64'd30;
					default: dim = 64'd31;
				endcase
				if (days < dim || mi == 11)
					done = 1'b1;
				else begin
					days -= dim;
					mi++;
				end
			end
			r.year = YEAR_W'(yr);
			r.month = MONTH_W'(mi + 1);
			r.day = DAY_W'(days + 1);
		end
		return r;
	endfunction

	// Counter value that lands on epoch second ts, plus a sub-second fraction
	function automatic logic [63:0] sample_for(input logic [63:0] ts, input logic [63:0] frac);
		return cfg_boot_cnt + (ts - 64'(cfg_boot_ep)) * eff_freq() + frac;
	endfunction

	// Epoch second aimed at calendar boundaries, the clamp and the saturation point
	function automatic logic [63:0] pick_epoch();
		logic [63:0]  ts, base;
		int unsigned  y;
		y = $urandom_range(1970, 10000);
		case ($urandom_range(0, 5))
			0: ts = rand64() % (64'(YEAR10000_START) + 64'd172800);
			1: begin
				base = days_to_year(y) * 86400;
				ts = base + 64'($urandom_range(0, 172800));
				if (base >= 86400)
					ts -= 86400;
			end
			2: ts = (days_to_year(y) + 58) * 86400 + 64'($urandom_range(0, 3 * 86400));
			3: begin
				y = 100 * $urandom_range(20, 99);
				ts = (days_to_year(y) + 64'($urandom_range(0, 365))) * 86400 +
					64'($urandom_range(0, 86399));
			end
			4: begin
				if ($urandom_range(0, 1))
					ts = 64'(EPOCH_MAX) - 64'($urandom_range(0, 1000));
				else
					ts = 64'(YEAR10000_START) + 64'($urandom_range(0, 200)) - 64'd100;
			end
			default: ts = rand64() & 64'(EPOCH_MAX);
		endcase
		return ts;
	endfunction

	// Mostly well-aimed samples, some raw noise and some behind the boot value
	function automatic logic [63:0] make_sample();
		logic [63:0] ts, s;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		ts = pick_epoch();
		if (pick == 0)
			s = rand64();
		else if (pick == 1)
			s = cfg_boot_cnt - 64'($urandom_range(1, 1000));
		else if (ts < 64'(cfg_boot_ep) || (ts - 64'(cfg_boot_ep)) > ALL_ONES / eff_freq())
			s = rand64();
		else
			s = sample_for(ts, rand64() % eff_freq());
		return s;
	endfunction

	task automatic queue_sample(input logic [63:0] s);
		sample_q.push_back(s);
		items_queued++;
	endtask

	task automatic queue_random(input int unsigned n);
		repeat (n) queue_sample(make_sample());
	endtask

	task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// let the register copy settle
		@(posedge clk);
	endtask

	// Write all three registers, then read them back
	task automatic set_config(input logic [63:0] ep, input logic [63:0] cnt,
		input logic [63:0] freq);
		apb_access(1'b1, REG_BOOT_EPOCH, ep);
		apb_access(1'b1, REG_BOOT_COUNTER, cnt);
		apb_access(1'b1, REG_COUNTER_FREQ, freq);
		apb_access(1'b0, REG_BOOT_EPOCH, '0);
		apb_access(1'b0, REG_BOOT_COUNTER, '0);
		apb_access(1'b0, REG_COUNTER_FREQ, '0);
		settings_n++;
	endtask

	// Hold until every queued sample has produced its result, then let the block settle
	task automatic wait_all_delivered();
		while (results_seen != items_queued) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Track register writes and check read data
	always @(posedge clk) begin
		if (arst_n && psel && penable && pready) begin
			if (pwrite) begin
				case (paddr[4:3])
					REG_BOOT_EPOCH: cfg_boot_ep = pwdata[BOOT_EP_W-1:0];
					REG_BOOT_COUNTER: cfg_boot_cnt = pwdata;
					REG_COUNTER_FREQ: cfg_freq = pwdata[FREQ_W-1:0];
					default: ;
				endcase
			end else begin
				case (paddr[4:3])
					REG_BOOT_EPOCH:
						if (prdata != 64'(cfg_boot_ep))
							report_mismatch("boot_epoch_seconds readback", prdata, 64'(cfg_boot_ep));
					REG_BOOT_COUNTER:
						if (prdata != cfg_boot_cnt)
							report_mismatch("boot_counter_value readback", prdata, cfg_boot_cnt);
					REG_COUNTER_FREQ:
						if (prdata != 64'(cfg_freq))
							report_mismatch("counter_frequency_hz readback", prdata, 64'(cfg_freq));
					default: ;
				endcase
			end
		end
	end

	// Present samples from the queue, with random gaps, and predict each accepted one
	always @(posedge clk or negedge arst_n) begin : sample_driver
		logic        nxt_valid;
		logic [63:0] nxt_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data = s_tdata;
			if (s_tvalid && s_tready)
				datetime_q.push_back(calc_datetime(s_tdata));
			if (!s_tvalid || s_tready) begin
				nxt_valid = 1'b0;
				if (send_gap > 0)
					send_gap--;
				else if (idle_en && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(0, 4);
				else if (sample_q.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_data = sample_q.pop_front();
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata <= nxt_data;
		end
	end

	// Stall the result stream in random bursts
	always @(posedge clk or negedge arst_n) begin : result_stall
		logic nxt_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			nxt_ready = 1'b1;
			if (recv_gap > 0) begin
				recv_gap--;
				nxt_ready = 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 4);
				nxt_ready = 1'b0;
			end
			m_tready <= nxt_ready;
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_monitor
		datetime_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (datetime_q.size() == 0)
				report_mismatch("result with nothing pending", 64'(m_tdata[39:0]), '0);
			else begin
				want = datetime_q.pop_front();
				if (m_tdata[39:0] != want.epoch)
					report_mismatch("epoch_seconds", 64'(m_tdata[39:0]), 64'(want.epoch));
				if (m_tdata[53:40] != want.year)
					report_mismatch("year", 64'(m_tdata[53:40]), 64'(want.year));
				if (m_tdata[57:54] != want.month)
					report_mismatch("month", 64'(m_tdata[57:54]), 64'(want.month));
				if (m_tdata[62:58] != want.day)
					report_mismatch("day_of_month", 64'(m_tdata[62:58]), 64'(want.day));
				if (m_tdata[67:63] != want.hour)
					report_mismatch("hour", 64'(m_tdata[67:63]), 64'(want.hour));
				if (m_tdata[73:68] != want.minute)
					report_mismatch("minute", 64'(m_tdata[73:68]), 64'(want.minute));
				if (m_tdata[79:74] != want.second)
					report_mismatch("second", 64'(m_tdata[79:74]), 64'(want.second));
				if (m_tuser[0] != want.oor)
					report_mismatch("out_of_range", 64'(m_tuser[0]), 64'(want.oor));
				if (want.oor)
					clamped_seen++;
				results_seen++;
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [63:0] ep, freq;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: 1 GHz counter, boot at epoch zero
		settings_n++;
		queue_sample(64'd0);
		queue_sample(64'd999999999);
		queue_sample(64'd1000000000);
		queue_sample(sample_for(64'd86399, 64'd999999999));
		queue_sample(ALL_ONES);
		queue_sample(sample_for((days_to_year(2000) + 59) * 86400, '0));
		// drain fully before the random part
		wait_all_delivered();
		queue_random(250);
		wait_all_delivered();

		// One tick per second: calendar corners, the clamp and saturation
		set_config('0, rand64(), 64'd1);
		queue_sample(sample_for((days_to_year(1972) + 59) * 86400, '0));
		queue_sample(sample_for((days_to_year(1972) + 365) * 86400 + 86399, '0));
		queue_sample(sample_for((days_to_year(2000) + 59) * 86400 + 43200, '0));
		queue_sample(sample_for((days_to_year(2100) + 58) * 86400 + 86399, '0));
		queue_sample(sample_for((days_to_year(2100) + 59) * 86400, '0));
		queue_sample(sample_for((days_to_year(2400) + 365) * 86400 + 86399, '0));
		queue_sample(sample_for(64'(YEAR10000_START) - 1, '0));
		queue_sample(sample_for(64'(YEAR10000_START), '0));
		queue_sample(sample_for(64'(EPOCH_MAX), '0));
		// counter behind the boot value wraps to a huge elapsed time
		queue_sample(cfg_boot_cnt - 1);
		queue_random(300);
		wait_all_delivered();

		// Zero frequency, boot at the last valid second, boot counter all ones
		set_config(64'(YEAR10000_START) - 1, ALL_ONES, '0);
		queue_sample(cfg_boot_cnt);
		queue_sample(cfg_boot_cnt + 1);
		queue_sample(cfg_boot_cnt + (64'(EPOCH_MAX) - 64'(cfg_boot_ep)));
		queue_sample(cfg_boot_cnt + (64'(EPOCH_MAX) - 64'(cfg_boot_ep)) + 1);
		queue_sample(64'h7FFF_FFFF_FFFF_FFFF);
		queue_random(200);
		wait_all_delivered();

		// Highest frequency, boot close to the clamp
		set_config(64'(YEAR10000_START) - 64'd1000000000, rand64(), FREQ_MAX);
		queue_sample(cfg_boot_cnt);
		queue_sample(cfg_boot_cnt + FREQ_MAX - 1);
		queue_sample(cfg_boot_cnt + FREQ_MAX);
		queue_sample(cfg_boot_cnt - 1);
		queue_random(200);
		wait_all_delivered();

		// Random settings with junk above each register's width
		apb_access(1'b1, REG_UNUSED, rand64());
		repeat (3) begin
			ep = rand64();
			ep[BOOT_EP_W-1:0] = BOOT_EP_W'(rand64() % 64'(YEAR10000_START));
			freq = rand64();
			if ($urandom_range(0, 1))
				freq[FREQ_W-1:0] = FREQ_W'($urandom_range(1, 1000));
			else
				freq[FREQ_W-1:0] = FREQ_W'(64'd1 + rand64() % FREQ_MAX);
			set_config(ep, rand64(), freq);
			queue_random(100);
			wait_all_delivered();
		end

		// Closing stretch at full rate on both sides
		idle_en = 1'b0;
		set_config(64'($urandom_range(0, 2000000000)), rand64(),
			64'($urandom_range(1, 1000) * 1000));
		queue_random(250);
		wait_all_delivered();

		if (datetime_q.size() != 0)
			report_mismatch("results never delivered", 64'(datetime_q.size()), '0);
		$display("Converted %0d counter samples under %0d register settings,",
			items_queued, settings_n);
		$display("%0d of them clamped at the end of year 9999; %0d mismatches.",
			clamped_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
